// File: rtl/core/nqsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nqsd_pkg: shared types, widths and constants of the QAM soft demapper
// Constellation steps, fold levels and pipeline control types.
// ---------------------------------------------------------------------------
package nqsd_pkg;

	localparam int SYM_W    = 16;              // Q3.12 symbol input
	localparam int LLR_W    = 16;              // Q11.4 soft bit output
	localparam int WORK_FR  = 20;              // working fraction bits
	localparam int IN_SHIFT = WORK_FR - (SYM_W - 4);
	localparam int H_W      = SYM_W + IN_SHIFT + 1;   // folded distance, signed
	localparam int A_W      = 20;              // step in Q.20
	localparam int BP_W     = H_W + 1;         // breakpoint compare width
	localparam int K_W      = 3;               // ramp segment index
	localparam int V_W      = H_W + K_W + 2;   // ramp value, signed
	localparam int P1_W     = V_W + A_W + 1;   // ramp times step
	localparam int INV_W    = 16;
	localparam int P2_W     = 64;              // product width
	localparam int RND_SH   = 40;
	localparam int R_W      = P2_W - RND_SH;
	localparam int NLANE    = 8;
	localparam int NSTAGE   = 8;
	localparam int CNT_W    = 4;
	localparam int MOD_W    = 3;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [A_W-1:0] STEP_QPSK   = 20'd741455; // 1/sqrt(2)
	localparam logic [A_W-1:0] STEP_16QAM  = 20'd331589; // 1/sqrt(10)
	localparam logic [A_W-1:0] STEP_64QAM  = 20'd161799; // 1/sqrt(42)
	localparam logic [A_W-1:0] STEP_256QAM = 20'd80422;  // 1/sqrt(170)

	localparam logic [MOD_W-1:0] RST_MOD_ORDER = 3'd1;
	localparam logic             RST_MAX_LOG   = 1'b1;
	localparam logic [INV_W-1:0] RST_INV_NOISE = 16'd64;

	typedef enum logic [MOD_W-1:0] {
		MOD_BPSK   = 3'd0,
		MOD_QPSK   = 3'd1,
		MOD_16QAM  = 3'd2,
		MOD_64QAM  = 3'd3,
		MOD_256QAM = 3'd4
	} mod_t;

	typedef enum logic [1:0] {
		REG_MOD_ORDER   = 2'd0,
		REG_USE_MAX_LOG = 2'd1,
		REG_INV_NOISE   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [NSTAGE-1:0] en;   // stage load enables, stage 1 at bit 0
	} pipe_ctl_t;

	// unused selector codes act as 256QAM
	function automatic mod_t mod_clamp(input logic [MOD_W-1:0] v);
		mod_t res;
		priority if (v > 3'd4) res = MOD_256QAM;
		else res = mod_t'(v);
		return res;
	endfunction

	function automatic logic [A_W-1:0] step_of(input mod_t m);
		logic [A_W-1:0] res;
		unique case (m)
			MOD_BPSK, MOD_QPSK: res = STEP_QPSK;
			MOD_16QAM:          res = STEP_16QAM;
			MOD_64QAM:          res = STEP_64QAM;
			MOD_256QAM:         res = STEP_256QAM;
			default:            res = STEP_256QAM;
		endcase
		return res;
	endfunction

	// c_j * A with c_j = 2^(L-1-j)
	function automatic logic [H_W-1:0] fold_level(input mod_t m, input int j);
		int lvl;
		logic [H_W-1:0] res;
		lvl = int'(m);
		res = '0;
		if (j < lvl)
			res = H_W'(step_of(m)) << (lvl - 1 - j);
		return res;
	endfunction

	// last ramp breakpoint index for soft bit pair j
	function automatic logic [K_W-1:0] kmax_of(input mod_t m, input logic max_log, input int j);
		int lvl;
		logic [K_W-1:0] res;
		lvl = int'(m);
		res = '0;
		if (max_log && j < lvl)
			res = K_W'((1 << (lvl - 1 - j)) - 1);
		return res;
	endfunction

	function automatic logic [CNT_W-1:0] llr_count_of(input mod_t m);
		logic [CNT_W-1:0] res;
		if (m == MOD_BPSK) res = CNT_W'(1);
		else res = CNT_W'(2 * int'(m));
		return res;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/nqsd_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nqsd_fold: per-axis fold chain
// Builds the folded distances h(j) of both axes and registers one per lane.
// ---------------------------------------------------------------------------
module nqsd_fold import nqsd_pkg::*; (
	input  wire logic                     clk,
	input  wire pipe_ctl_t                ctl,
	input  wire logic signed [SYM_W-1:0]  sym_re,
	input  wire logic signed [SYM_W-1:0]  sym_im,
	input  wire mod_t                     order,
	output logic signed [H_W-1:0]         h_s2 [NLANE]
);

	logic signed [H_W-1:0] hr [NLANE/2];
	logic signed [H_W-1:0] hi [NLANE/2];
	logic signed [H_W-1:0] lvl;

	always_comb begin
		hr[0] = H_W'(sym_re) <<< IN_SHIFT;
		hi[0] = H_W'(sym_im) <<< IN_SHIFT;
		lvl = '0;
		for (int j = 1; j < NLANE/2; j++) begin
			lvl = signed'(fold_level(order, j - 1));
			hr[j] = lvl - (hr[j-1] < 0 ? -hr[j-1] : hr[j-1]);
			hi[j] = lvl - (hi[j-1] < 0 ? -hi[j-1] : hi[j-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			// BPSK: one soft bit from re + im
			h_s2[0] <= (order == MOD_BPSK) ? hr[0] + hi[0] : hr[0];
			h_s2[1] <= hi[0];
			for (int j = 1; j < NLANE/2; j++) begin
				h_s2[2*j]   <= hr[j];
				h_s2[2*j+1] <= hi[j];
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/nqsd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nqsd_lane: one soft bit lane
// Piecewise ramp, scaling by step and noise, rounding and saturation.
// ---------------------------------------------------------------------------
module nqsd_lane import nqsd_pkg::*; (
	input  wire logic                    clk,
	input  wire pipe_ctl_t               ctl,
	input  wire logic signed [H_W-1:0]   h,
	input  wire logic [A_W-1:0]          step,
	input  wire logic [K_W-1:0]          kmax,
	input  wire logic [INV_W-1:0]        inv_noise,
	output logic signed [LLR_W-1:0]      llr_s7
);

	logic [H_W-1:0]          mag;
	logic [K_W-1:0]          k;
	logic [H_W-1:0]          diff;
	logic [K_W-1:0]          k_s3;
	logic [H_W-1:0]          diff_s3;
	logic                    neg_s3;
	logic [V_W-2:0]          vmag;
	logic signed [V_W-1:0]   v_s4;
	logic signed [P1_W-1:0]  p1_s5;
	logic signed [P2_W-1:0]  p2_s6;
	logic signed [P2_W-1:0]  rsum;
	logic signed [R_W-1:0]   r;
	logic signed [LLR_W-1:0] sat;

	// segment: count of breakpoints 2A, 4A, ... reached, up to kmax
	always_comb begin
		mag = h[H_W-1] ? H_W'(-h) : H_W'(h);
		k = '0;
		for (int b = 1; b < (1 << K_W); b++) begin
			if (b <= int'(kmax) &&
			    BP_W'(mag) >= BP_W'(step) * BP_W'(2 * b))
				k = k + K_W'(1);
		end
		diff = mag - H_W'(k * step);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			k_s3    <= k;
			diff_s3 <= diff;
			neg_s3  <= h[H_W-1];
		end
	end

	assign vmag = (V_W-1)'({1'b0, k_s3} + (K_W+1)'(1)) * (V_W-1)'(diff_s3);

	always_ff @(posedge clk) begin
		if (ctl.en[3])
			v_s4 <= neg_s3 ? -signed'({1'b0, vmag}) : signed'({1'b0, vmag});
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4])
			p1_s5 <= P1_W'(v_s4 * signed'({1'b0, step}));
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5])
			p2_s6 <= P2_W'(p1_s5 * signed'({1'b0, inv_noise}));
	end

	// round half up to Q.4, then saturate
	always_comb begin
		rsum = p2_s6 + (P2_W'(1) << (RND_SH - 1));
		r    = rsum[P2_W-1:RND_SH];
		priority if (r > R_W'((1 << (LLR_W - 1)) - 1))
			sat = {1'b0, {(LLR_W-1){1'b1}}};
		else if (r < -R_W'(1 << (LLR_W - 1)))
			sat = {1'b1, {(LLR_W-1){1'b0}}};
		else
			sat = r[LLR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6])
			llr_s7 <= sat;
	end

endmodule
`default_nettype wire

// File: rtl/core/nqsd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nqsd_merge: result assembly
// Gathers the lanes, clears soft bits past the count, output register.
// ---------------------------------------------------------------------------
module nqsd_merge import nqsd_pkg::*; (
	input  wire logic                    clk,
	input  wire pipe_ctl_t               ctl,
	input  wire mod_t                    order,
	input  wire logic signed [LLR_W-1:0] llr_s7 [NLANE],
	output logic signed [LLR_W-1:0]      llr_q [NLANE],
	output logic [CNT_W-1:0]             count_q
);

	logic [CNT_W-1:0] count;

	assign count = llr_count_of(order);

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			count_q <= count;
			for (int i = 0; i < NLANE; i++)
				llr_q[i] <= (i < int'(count)) ? llr_s7[i] : '0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/nr_qam_soft_demapper.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nr_qam_soft_demapper: 5G NR soft demapper, BPSK to 256QAM
// One received symbol in, one beat of up to eight LLRs out.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel: sym_re/sym_im (Q3.12) with in_valid/in_stall. A beat is
//    taken at a clock edge with in_valid high and in_stall low.
//  - Output channel: llr_0..llr_7 (Q11.4, saturated) and llr_count with
//    out_valid/out_stall. Soft bit 2j is from the real part, 2j+1 from the
//    imaginary part; bits at and above llr_count read zero.
//  - APB port: mod_order at 0x0, use_max_log at 0x4, inv_noise at 0x8.
//    Write only while no beat is in flight.
//  - Throughput: one symbol per clock while out_stall stays low, set by the
//    eight parallel lanes that each carry one soft bit through the pipeline.
//  - Pipeline: input register, fold chain, five lane stages, output register.
//  - Stall: each stage loads when it is empty or its successor moves, so
//    bubbles close up and input beats keep flowing while a result waits;
//    in_stall rises only when all stages hold data.
//  - Reset: pipeline empties, registers go to mod_order QPSK,
//    use_max_log 1, inv_noise 64 (1.0).
// ---------------------------------------------------------------------------
module nr_qam_soft_demapper import nqsd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// APB configuration
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	// symbol input
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [SYM_W-1:0] sym_re,
	input  wire logic signed [SYM_W-1:0] sym_im,
	// soft bit output
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [LLR_W-1:0]      llr_0,
	output logic signed [LLR_W-1:0]      llr_1,
	output logic signed [LLR_W-1:0]      llr_2,
	output logic signed [LLR_W-1:0]      llr_3,
	output logic signed [LLR_W-1:0]      llr_4,
	output logic signed [LLR_W-1:0]      llr_5,
	output logic signed [LLR_W-1:0]      llr_6,
	output logic signed [LLR_W-1:0]      llr_7,
	output logic [CNT_W-1:0]             llr_count
);

	logic [MOD_W-1:0]        mod_order_q;
	logic                    use_max_log_q;
	logic [INV_W-1:0]        inv_noise_q;
	logic                    wr_en;
	reg_idx_t                reg_idx;
	mod_t                    order;
	logic [A_W-1:0]          step;
	logic [NSTAGE-1:0]       vld_q;
	pipe_ctl_t               ctl;
	logic signed [SYM_W-1:0] re_s1;
	logic signed [SYM_W-1:0] im_s1;
	logic signed [H_W-1:0]   h_s2 [NLANE];
	logic signed [LLR_W-1:0] llr_s7 [NLANE];
	logic signed [LLR_W-1:0] llr_q [NLANE];

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_order_q   <= RST_MOD_ORDER;
			use_max_log_q <= RST_MAX_LOG;
			inv_noise_q   <= RST_INV_NOISE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MOD_ORDER:   mod_order_q   <= pwdata[MOD_W-1:0];
				REG_USE_MAX_LOG: use_max_log_q <= pwdata[0];
				REG_INV_NOISE:   inv_noise_q   <= pwdata[INV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MOD_ORDER:   prdata = DATA_W'(mod_order_q);
			REG_USE_MAX_LOG: prdata = DATA_W'(use_max_log_q);
			REG_INV_NOISE:   prdata = DATA_W'(inv_noise_q);
			default:         prdata = '0;
		endcase
	end

	assign order = mod_clamp(mod_order_q);
	assign step  = step_of(order);

	// ---------------- pipeline control ----------------
	// a stage loads when empty or when the stage after it moves
	always_comb begin
		ctl.en[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall;
		for (int i = NSTAGE - 2; i >= 0; i--)
			ctl.en[i] = !vld_q[i] || ctl.en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.en[0])
				vld_q[0] <= in_valid;
			for (int i = 1; i < NSTAGE; i++)
				if (ctl.en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign in_stall  = !ctl.en[0];
	assign out_valid = vld_q[NSTAGE-1];

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			re_s1 <= sym_re;
			im_s1 <= sym_im;
		end
	end

	nqsd_fold u_fold (
		.clk    (clk),
		.ctl    (ctl),
		.sym_re (re_s1),
		.sym_im (im_s1),
		.order  (order),
		.h_s2   (h_s2)
	);

	for (genvar g = 0; g < NLANE; g++) begin : g_lane
		nqsd_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.h         (h_s2[g]),
			.step      (step),
			.kmax      (kmax_of(order, use_max_log_q, g / 2)),
			.inv_noise (inv_noise_q),
			.llr_s7    (llr_s7[g])
		);
	end

	nqsd_merge u_merge (
		.clk     (clk),
		.ctl     (ctl),
		.order   (order),
		.llr_s7  (llr_s7),
		.llr_q   (llr_q),
		.count_q (llr_count)
	);

	assign llr_0 = llr_q[0];
	assign llr_1 = llr_q[1];
	assign llr_2 = llr_q[2];
	assign llr_3 = llr_q[3];
	assign llr_4 = llr_q[4];
	assign llr_5 = llr_q[5];
	assign llr_6 = llr_q[6];
	assign llr_7 = llr_q[7];

endmodule
`default_nettype wire

// File: rtl/core/nqsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nqsd_checker: port-level checks of the soft demapper
// Output beat hold, stall relation, soft bit count and cleared unused bit.
// ---------------------------------------------------------------------------
module nqsd_checker import nqsd_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_stall,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic signed [LLR_W-1:0] llr_0,
	input wire logic signed [LLR_W-1:0] llr_1,
	input wire logic [CNT_W-1:0]        llr_count
);

	// a stalled output beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(llr_0) && $stable(llr_count))
		else $error("stalled output beat changed");

	// an empty output stage means the whole pipe can move
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (llr_count == 4'd1 || llr_count == 4'd2 || llr_count == 4'd4 ||
		               llr_count == 4'd6 || llr_count == 4'd8))
		else $error("bad soft bit count");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && llr_count == 4'd1 |-> llr_1 == '0)
		else $error("unused soft bit not cleared");

endmodule

bind nr_qam_soft_demapper nqsd_checker u_nqsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.llr_0     (llr_0),
	.llr_1     (llr_1),
	.llr_count (llr_count)
);
`default_nettype wire

// File: sim/tb_nr_qam_soft_demapper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nr_qam_soft_demapper: regression bench for the QAM soft demapper
// Random and directed symbols under every modulation order, both LLR
// methods and several noise scales; each output beat is compared with a
// local fixed-point predictor. Both channels idle at random.
// ---------------------------------------------------------------------------
module tb_nr_qam_soft_demapper;
	import nqsd_pkg::*;

	// one expected output beat
	typedef struct {
		logic signed [LLR_W-1:0] llr [NLANE];
		logic [CNT_W-1:0]        cnt;
	} llr_beat_t;

	// one input symbol
	typedef struct {
		logic signed [SYM_W-1:0] re;
		logic signed [SYM_W-1:0] im;
	} sym_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SYM_W-1:0] sym_re = '0, sym_im = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [LLR_W-1:0] llr_0, llr_1, llr_2, llr_3, llr_4, llr_5, llr_6, llr_7;
	logic [CNT_W-1:0] llr_count;

	// predictor copy of the registers
	logic [MOD_W-1:0] cur_mod = RST_MOD_ORDER;
	logic             cur_max_log = RST_MAX_LOG;
	logic [INV_W-1:0] cur_inv = RST_INV_NOISE;

	sym_t      pending_syms[$];
	llr_beat_t expected_llrs[$];
	int        n_errors = 0;
	int        send_idle_pct = 0, recv_idle_pct = 0;
	longint    cycle_cnt = 0;

	localparam longint CYCLE_LIMIT = 400000;

	always #4 clk = ~clk;

	nr_qam_soft_demapper i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .sym_re, .sym_im,
		.out_valid, .out_stall, .llr_0, .llr_1, .llr_2, .llr_3, .llr_4, .llr_5,
		.llr_6, .llr_7, .llr_count
	);

	// ---- predictor -------------------------------------------------------

	// d * A * inv_noise * 4, rounded half up to Q.4, saturated
	function automatic logic signed [LLR_W-1:0] scale_llr(longint d, longint a);
		longint p, r, hi, lo;
		p = d * a * longint'(cur_inv);
		r = (p + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
		hi = (64'sd1 <<< (LLR_W - 1)) - 1;
		lo = -(64'sd1 <<< (LLR_W - 1));
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return LLR_W'(r);
	endfunction

	// odd piecewise ramp with slope growing at each 2A breakpoint
	function automatic longint llr_ramp(longint h, longint a, int kmax);
		longint m, v;
		int k;
		m = (h < 0) ? -h : h;
		k = 0;
		while (k < kmax && m >= 2 * longint'(k + 1) * a) k++;
		v = longint'(k + 1) * (m - longint'(k) * a);
		return (h < 0) ? -v : v;
	endfunction

	function automatic llr_beat_t demap_symbol(sym_t s);
		llr_beat_t b;
		longint re, im, a, c;
		int ord, kmax;
		re = longint'(s.re) <<< (WORK_FR - (SYM_W - 4));
		im = longint'(s.im) <<< (WORK_FR - (SYM_W - 4));
		ord = (cur_mod > 3'd4) ? 4 : int'(cur_mod);
		foreach (b.llr[i]) b.llr[i] = '0;
		if (ord == int'(MOD_BPSK)) begin
			b.llr[0] = scale_llr(re + im, longint'(STEP_QPSK));
			b.cnt = CNT_W'(1);
			return b;
		end
		case (ord)
			int'(MOD_QPSK):  a = longint'(STEP_QPSK);
			int'(MOD_16QAM): a = longint'(STEP_16QAM);
			int'(MOD_64QAM): a = longint'(STEP_64QAM);
			default:         a = longint'(STEP_256QAM);
		endcase
		for (int j = 0; j < ord; j++) begin
			c = 64'sd1 <<< (ord - 1 - j);
			kmax = cur_max_log ? int'(c) - 1 : 0;
			b.llr[2*j]   = scale_llr(llr_ramp(re, a, kmax), a);
			b.llr[2*j+1] = scale_llr(llr_ramp(im, a, kmax), a);
			re = c * a - ((re < 0) ? -re : re);
			im = c * a - ((im < 0) ? -im : im);
		end
		b.cnt = CNT_W'(2 * ord);
		return b;
	endfunction

	// ---- driver: predict at acceptance, hold payload while stalled -------
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_llrs.push_back(demap_symbol('{sym_re, sym_im}));
				void'(pending_syms.pop_front());
			end
			// decide the next beat only when the current one is gone or absent
			if (!in_valid || !in_stall) begin
				if ((in_valid && !in_stall ? pending_syms.size() : pending_syms.size()) != 0
				    && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sym_re   <= pending_syms[0].re;
					sym_im   <= pending_syms[0].im;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ---- monitor --------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		llr_beat_t w;
		logic signed [LLR_W-1:0] got [NLANE];
		if (arst_n && out_valid && !out_stall) begin
			got = '{llr_0, llr_1, llr_2, llr_3, llr_4, llr_5, llr_6, llr_7};
			if (expected_llrs.size() == 0) begin
				report_mismatch("unexpected beat, llr_count", llr_count, 0);
			end else begin
				w = expected_llrs.pop_front();
				if (llr_count !== w.cnt) report_mismatch("llr_count", llr_count, w.cnt);
				for (int i = 0; i < NLANE; i++)
					if (got[i] !== w.llr[i])
						report_mismatch($sformatf("llr_%0d", i), got[i], w.llr[i]);
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("nr_qam_soft_demapper regression: fail");
			$finish;
		end
	end

	// ---- stimulus -------------------------------------------------------
	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_MOD_ORDER:   cur_mod = val[MOD_W-1:0];
			REG_USE_MAX_LOG: cur_max_log = val[0];
			default:         cur_inv = val[INV_W-1:0];
		endcase
	endtask

	// wait until every queued symbol has come back, plus pipeline slack
	task automatic drain();
		while (pending_syms.size() != 0 || expected_llrs.size() != 0 || in_valid)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic logic signed [SYM_W-1:0] rand_coord();
		// mostly near the constellation, sometimes full range
		if ($urandom_range(3) == 0) return SYM_W'($urandom);
		return SYM_W'($signed($urandom_range(12000)) - 6000);
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			pending_syms.push_back('{rand_coord(), rand_coord()});
	endtask

	initial begin
		logic signed [SYM_W-1:0] corners [5];
		corners = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset setting first, then each order with field extremes
		for (int m = 0; m < 8; m++) begin
			if (m != 0) apb_write(REG_MOD_ORDER, DATA_W'(m == 7 ? 0 : m));
			foreach (corners[i])
				pending_syms.push_back('{corners[i], corners[(i + 1) % 5]});
			pending_syms.push_back('{16'sh0A1E, -16'sh1234});
			drain();
			if (m == 5) apb_write(REG_USE_MAX_LOG, 0);
			if (m == 6) apb_write(REG_INV_NOISE, 0);
		end
		apb_write(REG_MOD_ORDER, DATA_W'(MOD_256QAM));
		apb_write(REG_INV_NOISE, 32'hFFFF);
		foreach (corners[i]) pending_syms.push_back('{corners[i], corners[i]});
		drain();

		// random phases: each idling pattern over several register settings
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 88 : 0;
			recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 16 : 0;
			for (int s = 0; s < 7; s++) begin
				apb_write(REG_MOD_ORDER, DATA_W'($urandom_range(7)));
				apb_write(REG_USE_MAX_LOG, DATA_W'($urandom_range(1)));
				case ($urandom_range(3))
					0: apb_write(REG_INV_NOISE, 32'hFFFF);
					1: apb_write(REG_INV_NOISE, 32'd1);
					default: apb_write(REG_INV_NOISE, DATA_W'($urandom_range(2000)));
				endcase
				queue_random(83);
				drain();
			end
		end

		if (n_errors == 0) begin
			$display("nr_qam_soft_demapper regression: pass");
		end else begin
			$display("nr_qam_soft_demapper regression: fail");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/core/nqsd_pkg.sv
rtl/core/nqsd_fold.sv
rtl/core/nqsd_lane.sv
rtl/core/nqsd_merge.sv
rtl/core/nr_qam_soft_demapper.sv
rtl/core/nqsd_checker.sv
sim/tb_nr_qam_soft_demapper.sv
